/* src/lz4bd_pkg.sv */
// Shared types and constants for the LZ4 block decompressor.
package lz4bd_pkg;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_TOKEN,
        PH_LIT_EXT,
        PH_LITERAL,
        PH_OFF_LO,
        PH_OFF_HI,
        PH_MATCH_EXT,
        PH_COPY,
        PH_DONE,
        PH_ERROR
    } phase_t;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    localparam logic [3:0]  NIBBLE_EXT = 4'hF;
    localparam logic [7:0]  BYTE_EXT   = 8'hFF;
    localparam logic [31:0] MIN_MATCH  = 32'd4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  out_byte;
        logic        frame_done;
        logic        frame_error;
        logic [31:0] produced_total;
        logic        copy_pending;
    } out_item_t;

    // Write and read request from the sequencer to the history memory.
    typedef struct packed {
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [7:0]  wr_data;
        logic [15:0] rd_addr;
    } hist_req_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

/* src/lz4bd_history.sv */
// History window memory with one write and one registered read port plus forwarding.
module lz4bd_history #(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lz4bd_pkg::hist_req_t  req,
    input  logic                  rd_en,
    output logic [7:0]            rd_data
);
    localparam int AW = $clog2(WINDOW_BYTES);

    logic [7:0] mem [WINDOW_BYTES];
    logic [7:0] q_reg;
    logic       fwd_reg;
    logic [7:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        // The forwarded byte is held together with the read data while the pipe stalls.
        if (rd_en)
        begin
            q_reg        <= mem[req.rd_addr[AW-1:0]];
            fwd_data_reg <= req.wr_data;
        end
    end

    // A read of the entry being written in the same cycle takes the new byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= req.wr_en && (req.wr_addr[AW-1:0] == req.rd_addr[AW-1:0]);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;
endmodule

/* src/lz4_block_decompressor.sv */
// Top level of the LZ4 block decompressor: sequencer, history memory and output stage.
//
// Usage: input beats carry req_type and in_byte. A push (req_type 0) delivers one
// compressed byte: an 8-byte header (packed size, unpacked size, little endian),
// then LZ4 sequences. A pull (req_type 1) asks for the next match byte while
// copy_pending is reported. Each accepted beat yields at most one result beat,
// which passes the memory read in stage 1 and the output register in stage 2.
// One beat is accepted per cycle unless the receiver stalls; the rate is set
// by the single read-modify-write per beat on the history memory, with a pull
// whose source is the byte written by the beat before served by forwarding.
// After frame_done or frame_error every beat is accepted and dropped until reset.
// Reset clears the sequencer; the history memory is not cleared, since a match
// may only reach bytes written in the current frame.
// On a receiver stall the two-stage pipe holds; in_ready drops when both hold results.
// The user writes output_capacity via cfg_we/cfg_data only while idle; not enforced.
module lz4_block_decompressor #(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lz4bd_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lz4bd_pkg::out_item_t  out_data
);
    logic [31:0] cap_reg;
    lz4bd_pkg::phase_t phase_reg, phase_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [3:0]  nib_reg, nib_next;
    logic [31:0] lit_reg, lit_next;
    logic [31:0] mrem_reg, mrem_next;
    logic [15:0] dist_reg, dist_next;
    logic [31:0] written_reg, written_next;

    // Stage 1 (memory read) and stage 2 (output register).
    logic        s1_valid_reg, s1_emit_reg, s1_from_mem_reg;
    lz4bd_pkg::out_item_t s1_item_reg;
    lz4bd_pkg::out_item_t s1_view;
    logic        s2_valid_reg;
    lz4bd_pkg::out_item_t s2_item_reg;

    logic        advance, s2_free, accept;
    logic        emit, from_mem, dv;
    logic [7:0]  ob;
    lz4bd_pkg::hist_req_t hreq;
    logic [7:0]  rd_data;
    logic [31:0] packed_sz, unpacked_sz, packed_left, out_room, mlen;

    assign s2_free  = !s2_valid_reg || out_ready;
    assign advance  = !s1_valid_reg || s2_free;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    assign packed_sz   = hdr_reg[31:0];
    assign unpacked_sz = hdr_reg[63:32];
    assign packed_left = (consumed_reg >= packed_sz) ? 32'd0 : packed_sz - consumed_reg;
    assign out_room    = (written_reg >= cap_reg) ? 32'd0 : cap_reg - written_reg;
    assign mlen        = lz4bd_pkg::sat_add(mrem_reg, {24'd0, in_data.in_byte});

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_next      = hdr_reg;
        consumed_next = consumed_reg;
        nib_next      = nib_reg;
        lit_next      = lit_reg;
        mrem_next     = mrem_reg;
        dist_next     = dist_reg;
        written_next  = written_reg;
        dv            = 1'b0;
        ob            = in_data.in_byte;
        from_mem      = 1'b0;
        hreq.wr_en    = 1'b0;
        hreq.wr_addr  = written_reg[15:0];
        hreq.wr_data  = in_data.in_byte;
        hreq.rd_addr  = written_reg[15:0] - dist_reg;
        if (accept && phase_reg != lz4bd_pkg::PH_DONE && phase_reg != lz4bd_pkg::PH_ERROR)
        begin
            if (in_data.req_type == lz4bd_pkg::REQ_PULL)
            begin
                if (phase_reg == lz4bd_pkg::PH_COPY)
                begin
                    if (written_reg >= cap_reg)
                    begin
                        phase_next = lz4bd_pkg::PH_ERROR;
                    end
                    else
                    begin
                        // The write data comes from the registered memory read;
                        // it is written back from stage 1 below.
                        dv           = 1'b1;
                        from_mem     = 1'b1;
                        written_next = written_reg + 32'd1;
                        mrem_next    = mrem_reg - 32'd1;
                        if (mrem_reg == 32'd1)
                        begin
                            if (packed_left == 32'd0)
                            begin
                                phase_next = (cap_reg == unpacked_sz) ?
                                    lz4bd_pkg::PH_DONE : lz4bd_pkg::PH_ERROR;
                            end
                            else
                            begin
                                phase_next = lz4bd_pkg::PH_TOKEN;
                            end
                        end
                    end
                end
            end
            else if (phase_reg == lz4bd_pkg::PH_COPY)
            begin
                phase_next = lz4bd_pkg::PH_ERROR;
            end
            else if (phase_reg == lz4bd_pkg::PH_HEADER)
            begin
                hdr_next[consumed_reg[2:0]*8 +: 8] = in_data.in_byte;
                consumed_next = consumed_reg + 32'd1;
                if (consumed_reg[2:0] == 3'd7)
                begin
                    consumed_next = 32'd0;
                    phase_next = (hdr_reg[31:0] == 32'd0 && consumed_reg[2:0] != 3'd3 &&
                                  hdr_next[31:0] == 32'd0) ?
                        lz4bd_pkg::PH_ERROR : lz4bd_pkg::PH_TOKEN;
                end
            end
            else if (packed_left == 32'd0)
            begin
                phase_next = lz4bd_pkg::PH_ERROR;
            end
            else
            begin
                consumed_next = consumed_reg + 32'd1;
                unique case (phase_reg)
                    lz4bd_pkg::PH_TOKEN:
                    begin
                        nib_next = in_data.in_byte[3:0];
                        lit_next = {28'd0, in_data.in_byte[7:4]};
                        if (in_data.in_byte[7:4] == lz4bd_pkg::NIBBLE_EXT)
                        begin
                            phase_next = lz4bd_pkg::PH_LIT_EXT;
                        end
                        else if (in_data.in_byte[7:4] == 4'd0)
                        begin
                            phase_next = (packed_left - 32'd1 <= 32'd1 &&
                                          cap_reg == unpacked_sz) ?
                                lz4bd_pkg::PH_DONE : lz4bd_pkg::PH_OFF_LO;
                        end
                        else
                        begin
                            phase_next = (lit_next > packed_left - 32'd1 ||
                                          lit_next > out_room) ?
                                lz4bd_pkg::PH_ERROR : lz4bd_pkg::PH_LITERAL;
                        end
                    end
                    lz4bd_pkg::PH_LIT_EXT:
                    begin
                        lit_next = lz4bd_pkg::sat_add(lit_reg, {24'd0, in_data.in_byte});
                        if (in_data.in_byte != lz4bd_pkg::BYTE_EXT)
                        begin
                            phase_next = (lit_next > packed_left - 32'd1 ||
                                          lit_next > out_room) ?
                                lz4bd_pkg::PH_ERROR : lz4bd_pkg::PH_LITERAL;
                        end
                    end
                    lz4bd_pkg::PH_LITERAL:
                    begin
                        if (written_reg >= cap_reg)
                        begin
                            phase_next = lz4bd_pkg::PH_ERROR;
                        end
                        else
                        begin
                            dv           = 1'b1;
                            hreq.wr_en   = 1'b1;
                            written_next = written_reg + 32'd1;
                            lit_next     = lit_reg - 32'd1;
                            if (lit_reg == 32'd1)
                            begin
                                phase_next = (packed_left - 32'd1 <= 32'd1 &&
                                              cap_reg == unpacked_sz) ?
                                    lz4bd_pkg::PH_DONE : lz4bd_pkg::PH_OFF_LO;
                            end
                        end
                    end
                    lz4bd_pkg::PH_OFF_LO:
                    begin
                        dist_next  = {8'd0, in_data.in_byte};
                        phase_next = lz4bd_pkg::PH_OFF_HI;
                    end
                    lz4bd_pkg::PH_OFF_HI:
                    begin
                        dist_next = {in_data.in_byte, dist_reg[7:0]};
                        if (nib_reg == lz4bd_pkg::NIBBLE_EXT)
                        begin
                            mrem_next  = {28'd0, nib_reg};
                            phase_next = lz4bd_pkg::PH_MATCH_EXT;
                        end
                        else
                        begin
                            mrem_next  = {28'd0, nib_reg} + lz4bd_pkg::MIN_MATCH;
                            phase_next = (dist_next == 16'd0 ||
                                          {16'd0, dist_next} > written_reg ||
                                          {15'd0, dist_next} > 31'(WINDOW_BYTES) ||
                                          mrem_next > out_room) ?
                                lz4bd_pkg::PH_ERROR : lz4bd_pkg::PH_COPY;
                        end
                    end
                    lz4bd_pkg::PH_MATCH_EXT:
                    begin
                        mrem_next = mlen;
                        if (in_data.in_byte != lz4bd_pkg::BYTE_EXT)
                        begin
                            mrem_next  = lz4bd_pkg::sat_add(mlen, lz4bd_pkg::MIN_MATCH);
                            phase_next = (dist_reg == 16'd0 ||
                                          {16'd0, dist_reg} > written_reg ||
                                          {15'd0, dist_reg} > 31'(WINDOW_BYTES) ||
                                          mrem_next > out_room) ?
                                lz4bd_pkg::PH_ERROR : lz4bd_pkg::PH_COPY;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        // A pulled byte is written back from stage 1 once its read data is registered.
        if (s1_valid_reg && s1_from_mem_reg && advance)
        begin
            hreq.wr_en   = 1'b1;
            hreq.wr_addr = written_reg[15:0] - 16'd1;
            hreq.wr_data = rd_data;
        end
    end

    assign emit = dv || phase_next == lz4bd_pkg::PH_DONE ||
                  phase_next == lz4bd_pkg::PH_ERROR || phase_next == lz4bd_pkg::PH_COPY;

    // A literal and a pull write-back never share a cycle: a literal needs a
    // preceding push, so the previous beat was no pull.
    lz4bd_history #(.WINDOW_BYTES(WINDOW_BYTES)) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (hreq),
        .rd_en   (advance),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= 32'd0;
            phase_reg    <= lz4bd_pkg::PH_HEADER;
            hdr_reg      <= 64'd0;
            consumed_reg <= 32'd0;
            nib_reg      <= 4'd0;
            lit_reg      <= 32'd0;
            mrem_reg     <= 32'd0;
            dist_reg     <= 16'd0;
            written_reg  <= 32'd0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            phase_reg    <= phase_next;
            hdr_reg      <= hdr_next;
            consumed_reg <= consumed_next;
            nib_reg      <= nib_next;
            lit_reg      <= lit_next;
            mrem_reg     <= mrem_next;
            dist_reg     <= dist_next;
            written_reg  <= written_next;
            if (advance)
            begin
                s1_valid_reg <= accept && emit && phase_reg != lz4bd_pkg::PH_DONE &&
                                phase_reg != lz4bd_pkg::PH_ERROR;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // A pulled byte takes its value from the memory as it leaves stage 1.
    always_comb
    begin
        s1_view = s1_item_reg;
        if (s1_from_mem_reg)
        begin
            s1_view.out_byte = rd_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_from_mem_reg             <= from_mem;
            s1_emit_reg                 <= emit;
            s1_item_reg.data_valid      <= dv;
            s1_item_reg.out_byte        <= dv ? ob : 8'd0;
            s1_item_reg.frame_done      <= phase_next == lz4bd_pkg::PH_DONE;
            s1_item_reg.frame_error     <= phase_next == lz4bd_pkg::PH_ERROR;
            s1_item_reg.produced_total  <= (phase_next == lz4bd_pkg::PH_DONE) ?
                                           hdr_next[63:32] : 32'd0;
            s1_item_reg.copy_pending    <= phase_next == lz4bd_pkg::PH_COPY;
        end
        if (s2_free && s1_valid_reg && s1_emit_reg)
        begin
            s2_item_reg <= s1_view;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_item_reg;
endmodule
